// ===== src/rcsp_pkg.sv =====
// Shared types, constants and codes of the reference-counted slot pool.
package rcsp_pkg;

    localparam int SLOTS    = 128;
    localparam int MAX_REFS = 32767;

    localparam int WORD_W   = 16;
    localparam int ADDR_W   = $clog2(SLOTS);
    localparam int HEAD_W   = $clog2(SLOTS + 1);
    localparam int IDX_W    = 7;
    localparam int MODE_W   = 2;
    localparam int STAT_W   = 3;
    localparam int CNT_W    = 15;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_RETAIN = 2'd1,
        MODE_DROP   = 2'd2,
        MODE_QUERY  = 2'd3
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_FREED   = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_NOT_USE = 3'd3,
        STAT_SAT     = 3'd4
    } status_t;

    typedef struct packed {
        logic rd;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [HEAD_W-1:0] free_head;
    } dp_stat_t;

endpackage

// ===== src/rcsp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module rcsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/rcsp_ctrl.sv =====
// Controller of the slot pool: request sequencing and output word handshake.
module rcsp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output rcsp_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free   = !out_valid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.rd     = s_tready && s_tvalid;
    assign cmd.commit = (state_reg == ST_EXEC) && out_free;
    assign m_tvalid   = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold until the output register can take the result
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/rcsp_dpath.sv =====
// Datapath of the slot pool: slot word store, free-list head and result register.
module rcsp_dpath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rcsp_pkg::ctrl_cmd_t                  cmd,
    input  logic [rcsp_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic [rcsp_pkg::OUT_DATA_W-1:0]      m_tdata,
    output rcsp_pkg::dp_stat_t                   stat
);

    localparam int WORD_W = rcsp_pkg::WORD_W;
    localparam int ADDR_W = rcsp_pkg::ADDR_W;
    localparam int HEAD_W = rcsp_pkg::HEAD_W;
    localparam int IDX_W  = rcsp_pkg::IDX_W;
    localparam int CNT_W  = rcsp_pkg::CNT_W;
    localparam logic [HEAD_W-1:0] SLOTS_H = HEAD_W'(rcsp_pkg::SLOTS);
    localparam logic [WORD_W-1:0] MAX_W   = WORD_W'(rcsp_pkg::MAX_REFS);
    localparam logic [WORD_W-1:0] ONE_W   = WORD_W'(1);

    // request fields
    rcsp_pkg::mode_t  in_mode;
    logic [IDX_W-1:0] in_idx;

    assign in_mode = rcsp_pkg::mode_t'(s_tdata[1:0]);
    assign in_idx  = s_tdata[8:2];

    // state
    logic [HEAD_W-1:0]  free_head_reg, free_head_next;
    logic [rcsp_pkg::SLOTS-1:0] init_reg;

    // request registers
    rcsp_pkg::mode_t    req_mode_reg;
    logic [IDX_W-1:0]   req_idx_reg;
    logic [ADDR_W-1:0]  rd_addr_reg;
    logic               rd_init_reg;

    // result registers
    logic [IDX_W-1:0]     out_id_reg;
    rcsp_pkg::status_t    out_stat_reg;
    logic [CNT_W-1:0]     out_cnt_reg;
    logic                 out_use_reg;

    // RAM port
    logic [ADDR_W-1:0]  raddr;
    logic [WORD_W-1:0]  ram_rdata;
    logic               wr_c;
    logic [ADDR_W-1:0]  waddr_c;
    logic [WORD_W-1:0]  wdata_c;

    // execute stage
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  cnt;
    logic [HEAD_W-1:0]  idx_h;
    logic               live;
    logic [IDX_W-1:0]   res_id;
    rcsp_pkg::status_t  res_stat;
    logic [CNT_W-1:0]   res_cnt;
    logic               res_use;

    assign raddr = (in_mode == rcsp_pkg::MODE_ALLOC) ? free_head_reg[ADDR_W-1:0]
                                                      : ADDR_W'(in_idx);

    rcsp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (rcsp_pkg::SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_c),
        .waddr (waddr_c),
        .wdata (wdata_c),
        .re    (cmd.rd),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // an entry never written still holds its reset link, index plus one
    assign word  = rd_init_reg ? ram_rdata : (WORD_W'(rd_addr_reg) + ONE_W);
    assign cnt   = WORD_W'(0) - word;
    assign idx_h = HEAD_W'(req_idx_reg);
    assign live  = (idx_h < SLOTS_H) && word[WORD_W-1];

    always_comb begin
        free_head_next = free_head_reg;
        wr_c           = 1'b0;
        waddr_c        = rd_addr_reg;
        wdata_c        = word;
        res_id         = req_idx_reg;
        res_stat       = rcsp_pkg::STAT_OK;
        res_cnt        = cnt[CNT_W-1:0];
        res_use        = 1'b1;
        if (req_mode_reg == rcsp_pkg::MODE_ALLOC) begin
            if (free_head_reg >= SLOTS_H) begin
                res_id   = '0;
                res_stat = rcsp_pkg::STAT_FULL;
                res_cnt  = '0;
                res_use  = 1'b0;
            end else begin
                // pop the head; clamp a corrupt link to the empty mark
                free_head_next = (word <= WORD_W'(rcsp_pkg::SLOTS)) ? word[HEAD_W-1:0]
                                                                    : SLOTS_H;
                wr_c    = 1'b1;
                wdata_c = WORD_W'(0) - ONE_W;
                res_id  = IDX_W'(free_head_reg);
                res_cnt = CNT_W'(1);
            end
        end else if (!live) begin
            res_stat = rcsp_pkg::STAT_NOT_USE;
            res_cnt  = '0;
            res_use  = 1'b0;
        end else begin
            case (req_mode_reg)
                rcsp_pkg::MODE_RETAIN: begin
                    if (cnt >= MAX_W) begin
                        res_stat = rcsp_pkg::STAT_SAT;
                    end else begin
                        wr_c    = 1'b1;
                        wdata_c = word - ONE_W;
                        res_cnt = CNT_W'(cnt + ONE_W);
                    end
                end
                rcsp_pkg::MODE_DROP: begin
                    wr_c = 1'b1;
                    if (cnt == ONE_W) begin
                        // last reference: push the slot back on the free list
                        wdata_c        = WORD_W'(free_head_reg);
                        free_head_next = idx_h;
                        res_stat       = rcsp_pkg::STAT_FREED;
                        res_cnt        = '0;
                        res_use        = 1'b0;
                    end else begin
                        wdata_c = word + ONE_W;
                        res_cnt = CNT_W'(cnt - ONE_W);
                    end
                end
                default: begin
                    res_stat = rcsp_pkg::STAT_OK;
                end
            endcase
        end
        wr_c = wr_c && cmd.commit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= '0;
            init_reg      <= '0;
        end else if (cmd.commit) begin
            free_head_reg <= free_head_next;
            if (wr_c) begin
                init_reg[waddr_c] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            req_mode_reg <= in_mode;
            req_idx_reg  <= in_idx;
            rd_addr_reg  <= raddr;
            rd_init_reg  <= init_reg[raddr];
        end
        if (cmd.commit) begin
            out_id_reg   <= res_id;
            out_stat_reg <= res_stat;
            out_cnt_reg  <= res_cnt;
            out_use_reg  <= res_use;
        end
    end

    assign m_tdata = {6'd0, out_use_reg, out_cnt_reg, out_stat_reg, out_id_reg};
    assign stat.free_head = free_head_reg;

endmodule

// ===== src/refcounted_slot_pool.sv =====
// Top level of the reference-counted slot pool.
//
// Usage:
//   Requests arrive on the s_ channel, one word each: mode (allocate, retain,
//   drop, query) and the slot index. Each request yields exactly one result
//   word on the m_ channel: slot id, status, reference count and in-use flag.
//   A request is taken in the idle state, which starts the registered read of
//   its slot word from the store; in the execute state the word comes back and
//   the update is committed once the output register is free, and no further
//   request is taken until that commit. The result appears on m_tvalid the
//   cycle after the commit.
//   Reset (aresetn low at a clock edge) empties the output register, sets
//   the free-list head to slot 0 and marks every slot word as unwritten,
//   which reads back as the reset chain of index plus one; no clearing pass
//   is needed, so requests are taken in the first cycle after reset.
//   When the receiver stalls, the finished word waits in the output register
//   and one further request is still taken; its commit then holds until the
//   output register drains, and s_tready stays low meanwhile.
module refcounted_slot_pool (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [1:0] mode, [8:2] slot_index, [15:9] zero
    input  logic [rcsp_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [6:0] slot_id, [9:7] status, [24:10] ref_count, [25] in_use, [31:26] zero
    output logic [rcsp_pkg::OUT_DATA_W-1:0]     m_tdata
);

    rcsp_pkg::ctrl_cmd_t cmd;
    rcsp_pkg::dp_stat_t  stat;

    // sequencing and handshake
    rcsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // slot store, free list and result register
    rcsp_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .stat    (stat)
    );

    // a taken request blocks the next one for at least its execute cycle
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in flight");

    // the free-list head is a slot index or the empty mark
    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.free_head <= rcsp_pkg::HEAD_W'(rcsp_pkg::SLOTS))
        else $error("free-list head out of range");

    // a freed slot reports no references and no live allocation
    a_freed_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[9:7] == rcsp_pkg::STAT_FREED)
        |-> (m_tdata[24:10] == '0) && !m_tdata[25])
        else $error("freed slot reported with references");

    // a commit only follows a taken request
    a_commit_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !s_tready)
        else $error("commit without a pending request");

endmodule
